FILE: hdl/pcf_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pcf_pkg
// Shared types and constants for the per-pixel colour fade block.
// ---------------------------------------------------------------------------
package pcf_pkg;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned TIME_W  = 32;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned PROD_W  = TIME_W + CHAN_W;

    localparam logic KIND_FADE = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic [COLOR_W-1:0] from_color;
        logic [COLOR_W-1:0] to_color;
        logic [TIME_W-1:0]  begin_time;
        logic [TIME_W-1:0]  finish_time;
        logic [COLOR_W-1:0] shown_color;
    } t_entry;

    typedef struct packed {
        logic              done;
        logic [CHAN_W-1:0] quot;
    } t_div_rsp;

endpackage
`default_nettype wire

FILE: hdl/pcf_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// pcf_div
// Restoring divider, one quotient bit per cycle, 8-bit quotient.
// The caller guarantees the quotient is below 256.
// ---------------------------------------------------------------------------
module pcf_div (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [pcf_pkg::PROD_W-1:0]   i_num,
    input  wire logic [pcf_pkg::TIME_W-1:0]   i_den,
    output pcf_pkg::t_div_rsp                 o_rsp
);

    logic                        r_busy;
    logic                        r_done;
    logic [2:0]                  r_k;
    logic [pcf_pkg::PROD_W-1:0]  r_rem;
    logic [pcf_pkg::TIME_W-1:0]  r_den;
    logic [pcf_pkg::CHAN_W-1:0]  r_q;
    logic [pcf_pkg::PROD_W-1:0]  w_dsh;
    logic                        w_ge;

    assign w_dsh = {{(pcf_pkg::PROD_W-pcf_pkg::TIME_W){1'b0}}, r_den} << r_k;
    assign w_ge  = (r_rem >= w_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_k    <= 3'd7;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_k    <= 3'd7;
            end else if (r_busy) begin
                r_k <= r_k - 3'd1;
                if (r_k == 3'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_ge) begin
                r_rem <= r_rem - w_dsh;
            end
            r_q[r_k] <= w_ge;
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("divider done without a finished run");

endmodule
`default_nettype wire

FILE: hdl/per_pixel_timed_color_fade.sv
`default_nettype none
// ---------------------------------------------------------------------------
// per_pixel_timed_color_fade
// Per-pixel linear WRGB fade; state in one entry memory, one pixel at a time.
// ---------------------------------------------------------------------------
// Fade command: read and write of one entry, no result.
// Tick: per pixel a read (S_TRD) and a decide (S_EVAL) state, then, when interpolating,
// a multiply and a divide for each of the four channels (shared 8-step divider), then
// an issue state (S_OUT) that waits while the output stalls.
// Synchronous reset: idle, register zero, all entries marked invalid (read as zero).
module per_pixel_timed_color_fade #(
    parameter int unsigned PIXELS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_kind,
    input  wire logic [4:0]  i_pixel,
    input  wire logic [31:0] i_color,
    input  wire logic [31:0] i_now_ms,
    input  wire logic [31:0] i_end_ms,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [4:0]       o_pixel_out,
    output logic [31:0]      o_shown,
    output logic             o_changed,
    output logic             o_last
);

    localparam int unsigned IW = (PIXELS > 1) ? $clog2(PIXELS) : 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FRD  = 3'd1;
    localparam logic [2:0] S_FWR  = 3'd2;
    localparam logic [2:0] S_TRD  = 3'd3;
    localparam logic [2:0] S_EVAL = 3'd4;
    localparam logic [2:0] S_MUL  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    logic [2:0]         r_state;
    logic [15:0]        r_stagger;
    logic [IW-1:0]      r_idx;
    logic [31:0]        r_color;
    logic [31:0]        r_now;
    logic [31:0]        r_end;
    logic [31:0]        r_off;
    logic [1:0]         r_ch;
    logic [31:0]        r_num;
    logic [31:0]        r_den;
    logic               r_neg;
    logic [7:0]         r_lo;
    logic [31:0]        r_next;
    pcf_pkg::t_entry    r_ent;
    pcf_pkg::t_entry    r_rd;
    logic               r_rd_vld;
    pcf_pkg::t_entry    r_mem [PIXELS];
    logic [PIXELS-1:0]  r_vld;

    logic               r_out_valid;
    logic [4:0]         r_pixel_out;
    logic [31:0]        r_shown;
    logic               r_changed;
    logic               r_last;

    logic               w_in_acc;
    logic [6:0]         w_pix_ext;
    logic               w_pix_ok;
    logic               w_out_free;
    logic               w_is_last;
    logic               w_we;
    pcf_pkg::t_entry    w_wdata;
    pcf_pkg::t_entry    w_rd_ent;
    logic [7:0]         w_hi;
    logic [7:0]         w_lo;
    logic [7:0]         w_mag;
    logic [pcf_pkg::PROD_W-1:0] w_prod;
    logic               w_div_start;
    pcf_pkg::t_div_rsp  w_div;
    logic [7:0]         w_chan;
    logic [6:0]         w_idx_ext;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_in_acc   = i_in_valid && (r_state == S_IDLE);
    assign w_pix_ext  = {2'b00, i_pixel};
    assign w_pix_ok   = (w_pix_ext < 7'(PIXELS));
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_is_last  = (r_idx == IW'(PIXELS - 1));
    assign w_idx_ext  = 7'(r_idx);
    assign w_rd_ent   = r_rd_vld ? r_rd : '0;

    // channel operands
    assign w_hi   = r_ent.to_color[r_ch*8 +: 8];
    assign w_lo   = r_ent.from_color[r_ch*8 +: 8];
    assign w_mag  = (w_hi >= w_lo) ? (w_hi - w_lo) : (w_lo - w_hi);
    assign w_prod = r_num * w_mag;
    assign w_div_start = (r_state == S_MUL);
    assign w_chan = r_neg ? (r_lo - w_div.quot) : (r_lo + w_div.quot);

    always_comb begin
        w_we    = 1'b0;
        w_wdata = r_ent;
        if (r_state == S_FWR) begin
            w_we                = 1'b1;
            w_wdata             = w_rd_ent;
            w_wdata.from_color  = w_rd_ent.shown_color;
            w_wdata.to_color    = r_color;
            w_wdata.begin_time  = r_now + r_off;
            w_wdata.finish_time = r_end + r_off;
        end else if (r_state == S_OUT && w_out_free) begin
            w_we                = 1'b1;
            w_wdata.shown_color = r_next;
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_wdata;
        end
        r_rd <= r_mem[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (w_we) begin
                r_vld[r_idx] <= 1'b1;
            end
            r_rd_vld <= r_vld[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_stagger <= '0;
            r_idx     <= '0;
            r_ch      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_stagger <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        if (i_kind == pcf_pkg::KIND_TICK) begin
                            r_idx   <= '0;
                            r_state <= S_TRD;
                        end else if (w_pix_ok) begin
                            r_idx   <= w_pix_ext[IW-1:0];
                            r_state <= S_FRD;
                        end
                    end
                end
                S_FRD: r_state <= S_FWR;
                S_FWR: r_state <= S_IDLE;
                S_TRD: r_state <= S_EVAL;
                S_EVAL: begin
                    if (w_rd_ent.finish_time > r_now && w_rd_ent.begin_time <= r_now) begin
                        r_ch    <= 2'd3;
                        r_state <= S_MUL;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_MUL: r_state <= S_DIV;
                S_DIV: begin
                    if (w_div.done) begin
                        if (r_ch == 2'd0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_ch    <= r_ch - 2'd1;
                            r_state <= S_MUL;
                        end
                    end
                end
                S_OUT: begin
                    if (w_out_free) begin
                        if (w_is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_TRD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_color <= i_color;
            r_now   <= i_now_ms;
            r_end   <= i_end_ms;
            r_off   <= 32'(r_stagger) * 32'(i_pixel);
        end
        if (r_state == S_EVAL) begin
            r_ent <= w_rd_ent;
            r_num <= r_now - w_rd_ent.begin_time;
            r_den <= w_rd_ent.finish_time - w_rd_ent.begin_time;
            if (w_rd_ent.finish_time <= r_now) begin
                r_next <= w_rd_ent.to_color;
            end else begin
                r_next <= w_rd_ent.shown_color;
            end
        end
        if (r_state == S_MUL) begin
            r_neg <= (w_hi < w_lo);
            r_lo  <= w_lo;
        end
        if (r_state == S_DIV && w_div.done) begin
            r_next[r_ch*8 +: 8] <= w_chan;
        end
    end

    pcf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_prod),
        .i_den   (r_den),
        .o_rsp   (w_div)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_pixel_out <= w_idx_ext[4:0];
            r_shown     <= r_next;
            r_changed   <= (r_next != r_ent.shown_color);
            r_last      <= w_is_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pixel_out = r_pixel_out;
    assign o_shown     = r_shown;
    assign o_changed   = r_changed;
    assign o_last      = r_last;

    a_tick_starts_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_kind == pcf_pkg::KIND_TICK |=> r_idx == '0 && r_state == S_TRD)
        else $error("tick did not start at pixel zero");

    a_last_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_OUT && w_out_free && w_is_last |=> r_state == S_IDLE && r_last)
        else $error("walk did not end after last pixel");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> r_state == S_DIV)
        else $error("divider result outside divide state");

endmodule
`default_nettype wire
